// File: rtl/tlnef_pkg.sv
// ----------------------------------------------------------------------------
// Text line filter package
// Shared widths, byte codes, register indexes and types of the text line
// number and escape filter.
// ----------------------------------------------------------------------------
package tlnef_pkg;

  // Number of decimal digits in a line number prefix.
  localparam int NumDigits = 6;
  // Longest burst: number digits, tab, one escape byte and the byte itself.
  localparam int BurstMax  = NumDigits + 3;
  // Width of a burst length, able to hold BurstMax itself.
  localparam int CntW      = $clog2(BurstMax + 1);
  localparam int BcdW      = 4 * NumDigits;
  localparam int CfgIdxW   = 3;

  // Byte codes used in the output text.
  localparam logic [7:0] CharTab    = 8'd9;
  localparam logic [7:0] CharNl     = 8'd10;
  localparam logic [7:0] CharSpace  = 8'd32;
  localparam logic [7:0] CharDollar = 8'd36;
  localparam logic [7:0] CharZero   = 8'd48;
  localparam logic [7:0] CharI      = 8'd73;
  localparam logic [7:0] CharCaret  = 8'd94;
  localparam logic [7:0] CaretShift = 8'd64;
  localparam logic [7:0] CtrlLast   = 8'd31;
  localparam logic [7:0] PrintLast  = 8'd126;
  localparam logic [7:0] HighLast   = 8'd160;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgNumberAll      = 3'd0,
    CfgNumberNonblank = 3'd1,
    CfgSqueezeBlank   = 3'd2,
    CfgShowTabs       = 3'd3,
    CfgShowLineEnds   = 3'd4,
    CfgShowNonprint   = 3'd5
  } cfg_reg_e;

  // Option bits held by the block.
  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_tabs;
    logic show_line_ends;
    logic show_nonprint;
  } cfg_t;

  typedef logic [BurstMax-1:0][7:0] burst_t;

endpackage

// File: rtl/tlnef_in_if.sv
// ----------------------------------------------------------------------------
// Text line filter input channel
// Carries one raw text byte and its file start flag per beat.
// ----------------------------------------------------------------------------
interface tlnef_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       file_start;

  modport source (output valid, output in_byte, output file_start, input ready);
  modport sink   (input valid, input in_byte, input file_start, output ready);
endinterface

// File: rtl/tlnef_out_if.sv
// ----------------------------------------------------------------------------
// Text line filter output channel
// Carries one output text byte per beat, with a flag on the final byte.
// ----------------------------------------------------------------------------
interface tlnef_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// File: rtl/tlnef_cfg_if.sv
// ----------------------------------------------------------------------------
// Text line filter configuration channel
// Carries one register write, an index and a data bit, per beat.
// ----------------------------------------------------------------------------
interface tlnef_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tlnef_pkg::CfgIdxW-1:0]   wr_index;
  logic                            wr_data;

  modport source (output valid, output wr_index, output wr_data, input ready);
  modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

// File: rtl/text_line_number_escape_filter.sv
// ----------------------------------------------------------------------------
// Text line number and escape filter
// Numbers lines, squeezes blank lines and shows tabs, line ends and control
// bytes in caret notation, one input byte at a time.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat on in_i carries one text byte and a file start flag. Each
// input byte gives zero to nine output beats on out_o; last marks the final
// beat of one input byte. A squeezed newline gives no output beat at all.
// Register writes on cfg_i are always taken and should only be made while
// the block is idle.
// An accepted byte waits in the input register until the burst register is
// free; its first output beat is valid once the burst register has loaded it.
// Throughput: one input byte per cycle while each byte gives one output beat
// and the receiver is ready. The output burst register drains one beat per
// cycle while the receiver is ready, so a byte that gives more than one beat
// holds the input side until the last beat of its burst leaves.
// Reset clears all options, sets the line number to one and marks a line
// start. When the receiver stalls, the current burst holds and the input
// register takes one more byte before in_i.ready falls.
// ----------------------------------------------------------------------------
module text_line_number_escape_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  tlnef_cfg_if.sink   cfg_i,
  tlnef_in_if.sink    in_i,
  tlnef_out_if.source out_o
);

  // Configuration registers.
  tlnef_pkg::cfg_t cfg_q;

  // Input register.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_fs_q;

  // Stream state.
  logic [tlnef_pkg::BcdW-1:0] count_q, count_d;
  logic                       als_q, als_d;
  logic [1:0]                 brun_q, brun_d;

  // Output burst register: bytes shift towards slot zero, cnt_q beats remain.
  tlnef_pkg::burst_t          bst_q, bst_d;
  logic [tlnef_pkg::CntW-1:0] cnt_q, cnt_d;

  logic pop, bst_free, proc, drop;
  logic [tlnef_pkg::CntW-1:0] new_cnt;

  assign cfg_i.ready   = 1'b1;
  assign out_o.valid   = (cnt_q != '0);
  assign out_o.out_byte = bst_q[0];
  assign out_o.last    = (cnt_q == tlnef_pkg::CntW'(1));

  assign pop      = out_o.valid && out_o.ready;
  assign bst_free = (cnt_q == '0) || ((cnt_q == tlnef_pkg::CntW'(1)) && out_o.ready);
  assign proc     = in_vld_q && bst_free;
  assign in_i.ready = !in_vld_q || proc;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.wr_index)
        tlnef_pkg::CfgNumberAll:      cfg_q.number_all      <= cfg_i.wr_data;
        tlnef_pkg::CfgNumberNonblank: cfg_q.number_nonblank <= cfg_i.wr_data;
        tlnef_pkg::CfgSqueezeBlank:   cfg_q.squeeze_blank   <= cfg_i.wr_data;
        tlnef_pkg::CfgShowTabs:       cfg_q.show_tabs       <= cfg_i.wr_data;
        tlnef_pkg::CfgShowLineEnds:   cfg_q.show_line_ends  <= cfg_i.wr_data;
        tlnef_pkg::CfgShowNonprint:   cfg_q.show_nonprint   <= cfg_i.wr_data;
        default: ;
      endcase
    end
  end

  // Input register: holds one byte until the burst register can take it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.in_byte;
      in_fs_q   <= in_i.file_start;
    end
  end

  // Byte processing: stream state update and burst assembly.
  always_comb begin
    logic [tlnef_pkg::BcdW-1:0] cnt_eff;
    logic [tlnef_pkg::BcdW-1:0] cnt_inc;
    logic                       als_eff;
    logic [1:0]                 brun_eff;
    logic                       is_nl;
    logic                       num_en;
    logic                       pre_en;
    logic [7:0]                 pre_byte;
    logic [7:0]                 chr;
    logic                       full;
    logic                       carry;
    logic                       seen;
    logic [3:0]                 dig;
    logic [tlnef_pkg::CntW-1:0] pre_pos;
    logic [tlnef_pkg::CntW-1:0] chr_pos;
    logic [tlnef_pkg::NumDigits:0][7:0] num_chr;

    // A file start restarts the stream state before this byte.
    if (in_fs_q) begin
      cnt_eff  = tlnef_pkg::BcdW'(1);
      als_eff  = 1'b1;
      brun_eff = 2'd0;
    end else begin
      cnt_eff  = count_q;
      als_eff  = als_q;
      brun_eff = brun_q;
    end

    is_nl = (in_byte_q == tlnef_pkg::CharNl);

    // Blank line squeeze.
    drop   = 1'b0;
    brun_d = brun_eff;
    if (cfg_q.squeeze_blank) begin
      if (is_nl && als_eff) begin
        brun_d = (brun_eff == 2'd2) ? 2'd2 : brun_eff + 2'd1;
        drop   = (brun_d == 2'd2);
      end else begin
        brun_d = 2'd0;
      end
    end

    // Line number prefix; nonblank numbering takes precedence.
    if (cfg_q.number_nonblank) begin
      num_en = als_eff && !is_nl;
    end else begin
      num_en = cfg_q.number_all && als_eff;
    end

    // Saturating BCD increment of the line number.
    full = 1'b1;
    for (int p = 0; p < tlnef_pkg::NumDigits; p++) begin
      if (cnt_eff[4*p +: 4] != 4'd9) full = 1'b0;
    end
    carry   = 1'b1;
    cnt_inc = cnt_eff;
    for (int p = 0; p < tlnef_pkg::NumDigits; p++) begin
      if (carry) begin
        if (cnt_eff[4*p +: 4] >= 4'd9) begin
          cnt_inc[4*p +: 4] = 4'd0;
        end else begin
          cnt_inc[4*p +: 4] = cnt_eff[4*p +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (full) cnt_inc = cnt_eff;

    // Number text: leading zeros shown as spaces, then a tab.
    seen = 1'b0;
    for (int k = 0; k < tlnef_pkg::NumDigits; k++) begin
      dig = cnt_eff[4*(tlnef_pkg::NumDigits-1-k) +: 4];
      if (dig != 4'd0 || k == tlnef_pkg::NumDigits - 1) seen = 1'b1;
      if (dig > 4'd9) dig = 4'd9;
      num_chr[k] = seen ? (tlnef_pkg::CharZero + {4'd0, dig}) : tlnef_pkg::CharSpace;
    end
    num_chr[tlnef_pkg::NumDigits] = tlnef_pkg::CharTab;

    // Escapes: at most one of tab, line end and caret display applies.
    chr      = in_byte_q;
    pre_en   = 1'b0;
    pre_byte = tlnef_pkg::CharCaret;
    if (cfg_q.show_tabs && chr == tlnef_pkg::CharTab) begin
      pre_en = 1'b1;
      chr    = tlnef_pkg::CharI;
    end
    if (cfg_q.show_line_ends && chr == tlnef_pkg::CharNl) begin
      pre_en   = 1'b1;
      pre_byte = tlnef_pkg::CharDollar;
    end
    if (cfg_q.show_nonprint) begin
      if (chr < tlnef_pkg::CharTab
          || (chr > tlnef_pkg::CharNl && chr <= tlnef_pkg::CtrlLast)) begin
        pre_en = 1'b1;
        chr    = chr + tlnef_pkg::CaretShift;
      end else if (chr > tlnef_pkg::PrintLast && chr <= tlnef_pkg::HighLast) begin
        pre_en = 1'b1;
        chr    = chr - tlnef_pkg::CaretShift;
      end
    end

    // Burst assembly by slot position.
    pre_pos = num_en ? tlnef_pkg::CntW'(tlnef_pkg::NumDigits + 1) : '0;
    chr_pos = pre_pos + tlnef_pkg::CntW'(pre_en);
    new_cnt = chr_pos + tlnef_pkg::CntW'(1);

    // Next stream state.
    als_d   = drop ? als_eff : (chr == tlnef_pkg::CharNl);
    count_d = (num_en && !drop) ? cnt_inc : cnt_eff;

    // Burst register: load a new burst, or shift out one beat.
    bst_d = bst_q;
    cnt_d = cnt_q;
    if (pop) begin
      for (int k = 0; k < tlnef_pkg::BurstMax - 1; k++) begin
        bst_d[k] = bst_q[k+1];
      end
      bst_d[tlnef_pkg::BurstMax-1] = tlnef_pkg::CharSpace;
      cnt_d = cnt_q - tlnef_pkg::CntW'(1);
    end
    if (proc && !drop) begin
      for (int k = 0; k < tlnef_pkg::BurstMax; k++) begin
        if (num_en && k <= tlnef_pkg::NumDigits) begin
          bst_d[k] = num_chr[k];
        end else if (pre_en && tlnef_pkg::CntW'(k) == pre_pos) begin
          bst_d[k] = pre_byte;
        end else begin
          bst_d[k] = chr;
        end
      end
      cnt_d = new_cnt;
    end
  end

  // Stream state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= tlnef_pkg::BcdW'(1);
      als_q   <= 1'b1;
      brun_q  <= 2'd0;
      cnt_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (proc) begin
        count_q <= count_d;
        als_q   <= als_d;
        brun_q  <= brun_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bst_q <= bst_d;
  end

  // A burst never holds more beats than the longest prefix and byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tlnef_pkg::CntW'(tlnef_pkg::BurstMax))
    else $error("burst length out of range");

  // A squeezed newline leaves the block at a line start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && drop |=> als_q)
    else $error("line start lost on a squeezed newline");

  // A beat that is not the last of its burst is followed by another beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last |=> out_o.valid)
    else $error("burst ended before its last beat");

  // The input side only stalls while a byte waits in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_vld_q && !bst_free)
    else $error("input stalled without a waiting byte");

  // The lowest digit of the line number stays a decimal digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q[3:0] <= 4'd9)
    else $error("line number digit out of range");

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Text line filter testbench
// Drives text bytes and option writes into the line number and escape
// filter with random gaps and output stalls, predicts every output beat
// from its own model of the filter and checks each beat as it leaves.
// ----------------------------------------------------------------------------
module tb_top;
  import tlnef_pkg::*;

  // Cycles allowed for the block to settle after the last expected beat.
  localparam int Settle     = 4;
  // Cycles without any accepted beat before the run is abandoned.
  localparam int IdleLimit  = 200;
  // Lines counted in the long numbering run, past the first decimal carries.
  localparam int LongLines  = 30;
  localparam int PhaseItems = 16;
  localparam int NumPhases  = 8;
  // Number of option bits held by the block.
  localparam int OptW       = $bits(cfg_t);

  // Register indexes that the block does not implement.
  localparam logic [CfgIdxW-1:0] CfgUnusedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgUnusedHi = 3'd7;

  typedef enum logic [1:0] {
    OpByte,
    OpWrite,
    OpDrain
  } stim_kind_e;

  typedef struct {
    stim_kind_e         kind;
    logic [7:0]         text_byte;
    logic               file_start;
    logic [CfgIdxW-1:0] wr_index;
    logic               wr_data;
    int                 gap;
  } stim_op_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       last;
  } text_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tlnef_cfg_if cfg_if ();
  tlnef_in_if  in_if ();
  tlnef_out_if out_if ();

  text_line_number_escape_filter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Stimulus still to be driven and output beats still awaited.
  stim_op_t   stim_q[$];
  text_beat_t text_out_q[$];

  // Handshakes seen at the last rising edge.
  logic in_fire  = 1'b0;
  logic cfg_fire = 1'b0;
  logic out_fire = 1'b0;

  int err_cnt  = 0;
  int idle_cnt = 0;

  // Driver and receiver pacing.
  int gap_left      = 0;
  int drain_cnt     = 0;
  int in_calm_left  = 0;
  int out_calm_left = 0;
  int out_wait      = 0;

  // Model of the filter: options, line number and line state.
  cfg_t            opt;
  logic [BcdW-1:0] line_bcd;
  logic            at_start;
  logic [1:0]      blank_run_cnt;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Work out the output beats that one accepted text byte gives.
  task automatic predict_filter(input logic [7:0] text_byte, input logic file_start);
    logic [7:0] c;
    logic [7:0] burst[$];
    logic [3:0] digit;
    logic       seen;
    logic       full;
    logic       carry;
    text_beat_t beat;
    int         k;
    c = text_byte;
    if (file_start) begin
      line_bcd      = BcdW'(1);
      at_start      = 1'b1;
      blank_run_cnt = 2'd0;
    end
    // A newline that would make a second blank line in a row is dropped.
    if (opt.squeeze_blank) begin
      if (c == CharNl && at_start) begin
        if (blank_run_cnt < 2'd2) blank_run_cnt++;
        if (blank_run_cnt > 2'd1) return;
      end else begin
        blank_run_cnt = 2'd0;
      end
    end
    // Line number prefix; nonblank numbering takes precedence.
    if ((opt.number_nonblank && at_start && c != CharNl) ||
        (!opt.number_nonblank && opt.number_all && at_start)) begin
      seen = 1'b0;
      for (k = NumDigits - 1; k >= 0; k--) begin
        digit = line_bcd[4*k +: 4];
        if (digit != 4'd0 || k == 0) seen = 1'b1;
        burst.push_back(seen ? CharZero + {4'd0, digit} : CharSpace);
      end
      burst.push_back(CharTab);
      // The count stops at all nines.
      full = 1'b1;
      for (k = 0; k < NumDigits; k++) begin
        if (line_bcd[4*k +: 4] != 4'd9) full = 1'b0;
      end
      if (!full) begin
        carry = 1'b1;
        for (k = 0; k < NumDigits && carry; k++) begin
          if (line_bcd[4*k +: 4] == 4'd9) begin
            line_bcd[4*k +: 4] = 4'd0;
          end else begin
            line_bcd[4*k +: 4] = line_bcd[4*k +: 4] + 4'd1;
            carry = 1'b0;
          end
        end
      end
    end
    if (opt.show_tabs && c == CharTab) begin
      burst.push_back(CharCaret);
      c = CharI;
    end
    if (opt.show_line_ends && c == CharNl) burst.push_back(CharDollar);
    if (opt.show_nonprint) begin
      if (c < CharTab || (c > CharNl && c <= CtrlLast) || (c > PrintLast && c <= HighLast)) begin
        burst.push_back(CharCaret);
        c = (c > PrintLast) ? c - CaretShift : c + CaretShift;
      end
    end
    burst.push_back(c);
    at_start = (c == CharNl);
    for (k = 0; k < burst.size(); k++) begin
      beat.out_byte = burst[k];
      beat.last     = (k == burst.size() - 1);
      text_out_q.push_back(beat);
    end
  endtask

  // Queue one text byte, drawing the sender's gap in front of it.
  task automatic add_byte(input logic [7:0] text_byte, input logic file_start);
    stim_op_t op;
    op.kind       = OpByte;
    op.text_byte  = text_byte;
    op.file_start = file_start;
    op.wr_index   = '0;
    op.wr_data    = 1'b0;
    if (in_calm_left > 0) begin
      in_calm_left--;
      op.gap = 0;
    end else if ($urandom_range(0, 7) == 0) begin
      in_calm_left = $urandom_range(10, 40);
      op.gap = 0;
    end else begin
      op.gap = $urandom_range(0, 5);
    end
    stim_q.push_back(op);
  endtask

  // Queue a register write, preceded by a pause until the block is idle.
  task automatic add_write(input logic [CfgIdxW-1:0] wr_index, input logic wr_data);
    stim_op_t op;
    op.kind       = OpDrain;
    op.text_byte  = '0;
    op.file_start = 1'b0;
    op.wr_index   = wr_index;
    op.wr_data    = wr_data;
    op.gap        = 0;
    stim_q.push_back(op);
    op.kind = OpWrite;
    stim_q.push_back(op);
  endtask

  task automatic add_opts(input cfg_t o);
    add_write(CfgNumberAll,      o.number_all);
    add_write(CfgNumberNonblank, o.number_nonblank);
    add_write(CfgSqueezeBlank,   o.squeeze_blank);
    add_write(CfgShowTabs,       o.show_tabs);
    add_write(CfgShowLineEnds,   o.show_line_ends);
    add_write(CfgShowNonprint,   o.show_nonprint);
  endtask

  // Draw a text byte from a mix of printable, tab, control and high bytes.
  function automatic logic [7:0] draw_text_byte();
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      b = 8'($urandom_range(CharSpace, PrintLast));
    end else if (pick < 65) begin
      b = CharTab;
    end else if (pick < 80) begin
      b = 8'($urandom_range(0, CtrlLast));
      if (b == CharNl) b = CharNl + 8'd1;
    end else begin
      b = 8'($urandom_range(PrintLast + 1, 255));
    end
    return b;
  endfunction

  // Fill the stimulus queue: directed cases, a long count, then random text.
  task automatic build_stimulus();
    cfg_t o;
    int   phase;
    int   cnt;
    int   len;
    int   k;
    logic fs;
    // Extremes of the byte with every option off.
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(CharZero, 1'b0);
    add_byte(CharNl, 1'b0);
    // Every option on, both numbering bits among them.
    o = '1;
    add_opts(o);
    add_byte(CharNl, 1'b0);
    add_byte(CharNl, 1'b0);
    add_byte(CharNl, 1'b0);
    add_byte(CharTab, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(HighLast, 1'b0);
    add_byte(HighLast + 8'd1, 1'b0);
    add_byte(CtrlLast, 1'b0);
    add_byte(CharNl + 8'd1, 1'b0);
    add_byte(CharTab - 8'd1, 1'b0);
    add_byte(CharSpace, 1'b0);
    add_byte(PrintLast, 1'b0);
    add_byte(CharNl, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(CharNl, 1'b0);
    add_byte(CharNl, 1'b1);
    add_byte(CharNl, 1'b0);
    // Writes to indexes the block does not have must change nothing.
    add_write(CfgUnusedLo, 1'b0);
    add_write(CfgUnusedHi, 1'b1);
    add_byte(CharTab, 1'b0);
    add_byte(CharNl, 1'b0);
    // Number every line of a long run of blank lines.
    o = '0;
    o.number_all = 1'b1;
    add_opts(o);
    add_byte(CharNl, 1'b1);
    for (k = 1; k < LongLines; k++) add_byte(CharNl, 1'b0);
    // Random text in phases with different option settings.
    for (phase = 0; phase < NumPhases; phase++) begin
      if (phase == 0) o = '0;
      else if (phase == 1) o = '1;
      else o = cfg_t'(OptW'($urandom));
      add_opts(o);
      if (phase == 2) add_write(CfgUnusedLo, 1'b1);
      cnt = 0;
      while (cnt < PhaseItems) begin
        if ($urandom_range(0, 99) < 85) begin
          // A well-formed line, sometimes blank, sometimes opening a file.
          fs = ($urandom_range(0, 99) < 8);
          if ($urandom_range(0, 99) < 25) begin
            len = $urandom_range(1, 3);
            for (k = 0; k < len; k++) add_byte(CharNl, fs && k == 0);
            cnt += len;
          end else begin
            len = $urandom_range(1, 8);
            for (k = 0; k < len; k++) add_byte(draw_text_byte(), fs && k == 0);
            add_byte(CharNl, 1'b0);
            cnt += len + 1;
          end
        end else begin
          // Raw noise with stray file start flags.
          len = $urandom_range(1, 3);
          for (k = 0; k < len; k++) add_byte(8'($urandom), $urandom_range(0, 4) == 0);
          cnt += len;
        end
      end
    end
  endtask

  // Driver: presents the queued beats at the falling edge.
  always @(negedge clk_i) begin
    logic     nv;
    logic     cv;
    stim_op_t op;
    if (rst_ni) begin
      nv = in_if.valid;
      cv = cfg_if.valid;
      if (in_fire) nv = 1'b0;
      if (cfg_fire) cv = 1'b0;
      if (!nv && !cv && stim_q.size() != 0) begin
        op = stim_q[0];
        if (op.kind == OpDrain) begin
          // Hold off until every expected beat has come and the block settles.
          if (text_out_q.size() != 0) begin
            drain_cnt = 0;
          end else if (drain_cnt < Settle) begin
            drain_cnt++;
          end else begin
            void'(stim_q.pop_front());
            drain_cnt = 0;
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          void'(stim_q.pop_front());
          if (op.kind == OpByte) begin
            in_if.in_byte    <= op.text_byte;
            in_if.file_start <= op.file_start;
            nv = 1'b1;
          end else begin
            cfg_if.wr_index <= op.wr_index;
            cfg_if.wr_data  <= op.wr_data;
            cv = 1'b1;
          end
          gap_left = (stim_q.size() != 0) ? stim_q[0].gap : 0;
        end
      end
      in_if.valid  <= nv;
      cfg_if.valid <= cv;
    end
  end

  // Receiver: after an accepted beat, may stall for a drawn number of cycles.
  always @(negedge clk_i) begin
    logic r;
    int   w;
    if (rst_ni) begin
      r = out_if.ready;
      if (out_wait > 0) begin
        out_wait--;
        if (out_wait == 0) r = 1'b1;
      end else if (out_fire) begin
        if (out_calm_left > 0) begin
          out_calm_left--;
          w = 0;
        end else if ($urandom_range(0, 7) == 0) begin
          out_calm_left = $urandom_range(10, 60);
          w = 0;
        end else begin
          w = $urandom_range(0, 5);
        end
        if (w > 0) begin
          r = 1'b0;
          out_wait = w;
        end
      end
      out_if.ready <= r;
    end
  end

  // Monitor: records handshakes, updates the model and checks output beats.
  always @(posedge clk_i) begin
    text_beat_t want;
    if (rst_ni) begin
      in_fire  <= in_if.valid && in_if.ready;
      cfg_fire <= cfg_if.valid && cfg_if.ready;
      out_fire <= out_if.valid && out_if.ready;
      if (out_if.valid && out_if.ready) begin
        if (text_out_q.size() == 0) begin
          $error("out_byte: expected no beat, got %02h", out_if.out_byte);
          err_cnt++;
        end else begin
          want = text_out_q.pop_front();
          if (out_if.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_if.out_byte);
            err_cnt++;
          end
          if (out_if.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_if.last);
            err_cnt++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.wr_index)
          CfgNumberAll:      opt.number_all      = cfg_if.wr_data;
          CfgNumberNonblank: opt.number_nonblank = cfg_if.wr_data;
          CfgSqueezeBlank:   opt.squeeze_blank   = cfg_if.wr_data;
          CfgShowTabs:       opt.show_tabs       = cfg_if.wr_data;
          CfgShowLineEnds:   opt.show_line_ends  = cfg_if.wr_data;
          CfgShowNonprint:   opt.show_nonprint   = cfg_if.wr_data;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) predict_filter(in_if.in_byte, in_if.file_start);
      if ((in_if.valid && in_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (out_if.valid && out_if.ready)) begin
        idle_cnt = 0;
      end else begin
        idle_cnt++;
      end
    end
  end

  // Watchdog: gives up when nothing has moved for too long.
  initial begin
    while (idle_cnt < IdleLimit) @(posedge clk_i);
    $display("text_line_number_escape_filter: mismatch");
    $finish;
  end

  // Reset, stimulus and end of run.
  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.in_byte     = '0;
    in_if.file_start  = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.wr_index   = '0;
    cfg_if.wr_data    = 1'b0;
    out_if.ready      = 1'b1;
    opt               = '0;
    line_bcd          = BcdW'(1);
    at_start          = 1'b1;
    blank_run_cnt     = 2'd0;
    build_stimulus();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (stim_q.size() != 0 || in_if.valid || cfg_if.valid || text_out_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (Settle * 4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("text_line_number_escape_filter: match");
    end else begin
      $display("text_line_number_escape_filter: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tlnef_pkg.sv
rtl/tlnef_in_if.sv
rtl/tlnef_out_if.sv
rtl/tlnef_cfg_if.sv
rtl/text_line_number_escape_filter.sv
tb/sv/tb_top.sv
